// ===== design/mesh_route_compute_with_route_table_assert.svh =====
// Assertion macros for the mesh route compute block.
`ifndef MESH_ROUTE_COMPUTE_WITH_ROUTE_TABLE_ASSERT_SVH
`define MESH_ROUTE_COMPUTE_WITH_ROUTE_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mrc_pkg.sv =====
// Types, codes and helpers for the mesh route compute block.
package mrc_pkg;

    localparam int ROUTER_W    = 10;
    localparam int COLS_W      = 6;
    localparam int KEY_W       = 24;
    localparam int DIV_STEPS   = ROUTER_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int MAX_ROUTERS = 1024;   // power of two: reduction is a bit slice
    localparam int ROW_W       = ROUTER_W + 1;  // row + 1 may reach 1024
    localparam int ADDR_SUM_W  = ROW_W + COLS_W;

    typedef enum logic [1:0] {
        OP_HEAD = 2'd0,
        OP_DATA = 2'd1,
        OP_TAIL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MODE_XY    = 2'd0,
        MODE_YX    = 2'd1,
        MODE_ADAPT = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CFG_MODE = 2'd0,
        CFG_COLS = 2'd1,
        CFG_OWN  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WORK,
        ST_HOP,
        ST_ADDR,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic [COLS_W-1:0]   rem;
        logic [ROUTER_W-1:0] quo;
    } div_t;

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    function automatic div_t div_step(input logic [COLS_W-1:0] rem,
                                      input logic [ROUTER_W-1:0] quo,
                                      input logic [COLS_W-1:0] divisor);
        logic [COLS_W:0] trial;
        logic [COLS_W:0] diff;
        logic            fits;
        div_t            res;
        trial   = {rem, quo[ROUTER_W-1]};
        diff    = trial - {1'b0, divisor};
        fits    = (trial >= {1'b0, divisor});
        res.rem = fits ? diff[COLS_W-1:0] : trial[COLS_W-1:0];
        res.quo = {quo[ROUTER_W-2:0], fits};
        return res;
    endfunction

endpackage

// ===== design/mrc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mrc_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/mesh_route_compute_with_route_table.sv =====
// Next-hop unit for one router of a 2D mesh, with a per-packet route table.
//
// Input channel s_*: one flit per item; op in s_tuser, the rest in s_tdata.
// Result channel m_*: one result per head, data or tail flit; op 3 is taken
// and dropped without a result. Config channel cfg_*: index 0 routing mode,
// 1 mesh columns, 2 own router number; always ready. The user writes it only
// while idle; the block does not enforce this.
// Each item walks the route table memory one entry per cycle (one read port,
// registered read data) while two restoring dividers split the own and the
// destination router numbers into row and column, one bit per cycle. Then state
// HOP picks the direction, state ADDR forms row * columns + column, and state
// UPDATE writes the table and loads the output register.
// The work state lasts until both the table walk and the division are done.
// One item is in work at a time: a new flit is accepted only once the block
// is back in idle, after its result is loaded into the output register.
// A finished result waits in the output register while the next item is
// accepted; if the receiver stalls with a result still held, the next result
// waits in its final cycle until the register frees.
// Reset clears the route table valid bits and both channels, and sets the
// config and state registers to defaults; the table memory is not cleared.
`include "mesh_route_compute_with_route_table_assert.svh"

module mesh_route_compute_with_route_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    // flit input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // msg_num[15:0], pkt_num[23:16], dest_router[33:24],
                                   // x_neighbor_free[34], y_neighbor_free[35], zero[39:36]
    input  logic [1:0]  s_tuser,   // op[1:0]
    // route result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // next_router[9:0], zero[15:10]
    output logic [2:0]  m_tuser    // eject_local[0], route_missing[1], table_full[2]
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = IDX_W + 1;
    localparam int ENT_W  = mrc_pkg::KEY_W + mrc_pkg::ROUTER_W;
    localparam int RW     = mrc_pkg::ROUTER_W;
    localparam int CW     = mrc_pkg::COLS_W;
    localparam int YW     = mrc_pkg::ROW_W;
    localparam int SW     = mrc_pkg::ADDR_SUM_W;
    localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(TABLE_ENTRIES);

    // configuration
    logic [1:0]    mode_reg;
    logic [CW-1:0] cols_reg;
    logic [RW-1:0] own_reg;
    logic [CW-1:0] cols_eff;

    // state machine
    mrc_pkg::state_t state_reg, state_next;
    logic            s_accept;
    logic            scan_done;
    logic            out_load;

    // latched item
    logic [1:0]                  op_reg;
    logic [mrc_pkg::KEY_W-1:0]   key_reg;
    logic [RW-1:0]               dest_reg;
    logic                        xfree_reg;
    logic                        op_known;

    // dividers
    logic [mrc_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [RW-1:0] dest_quo_reg, own_quo_reg;
    logic [CW-1:0] dest_rem_reg, own_rem_reg;
    mrc_pkg::div_t dest_step, own_step;

    // table walk
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     cmp_vld_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     found_reg;
    logic [IDX_W-1:0]         match_idx_reg;
    logic                     free_found_reg;
    logic [IDX_W-1:0]         free_idx_reg;
    logic [RW-1:0]            hop_rd_reg;
    logic [ENT_W-1:0]         ram_rdata;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;

    // hop computation
    logic          xmove, ymove, take_x;
    logic [CW-1:0] nx;
    logic [YW-1:0] ny;
    logic [CW-1:0] sel_x_reg;
    logic [YW-1:0] sel_y_reg;
    logic          at_dest_reg;
    logic [SW-1:0] addr_sum;
    logic [RW-1:0] next_calc_reg;

    // result
    logic          is_head, is_tail;
    logic [RW-1:0] res_next;
    logic          res_eject, res_missing, res_full;
    logic          m_valid_reg;
    logic [RW-1:0] m_next_reg;
    logic [2:0]    m_flags_reg;

    assign cols_eff = (cols_reg == '0) ? CW'(1) : cols_reg;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= mrc_pkg::MODE_XY;
            cols_reg <= CW'(4);
            own_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mrc_pkg::CFG_MODE: mode_reg <= cfg_data[1:0];
                mrc_pkg::CFG_COLS: cols_reg <= cfg_data[CW-1:0];
                mrc_pkg::CFG_OWN:  own_reg  <= cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- control ----------------
    assign s_tready  = (state_reg == mrc_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign op_known  = (s_tuser == mrc_pkg::OP_HEAD) || (s_tuser == mrc_pkg::OP_DATA) ||
                       (s_tuser == mrc_pkg::OP_TAIL);
    assign scan_done = (cnt_reg == ENTRIES_CNT) && !cmp_vld_reg;

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            mrc_pkg::ST_IDLE: begin
                if (s_accept && op_known) state_next = mrc_pkg::ST_WORK;
            end
            mrc_pkg::ST_WORK: begin
                if (scan_done && div_cnt_reg == '0) state_next = mrc_pkg::ST_HOP;
            end
            mrc_pkg::ST_HOP:  state_next = mrc_pkg::ST_ADDR;
            mrc_pkg::ST_ADDR: state_next = mrc_pkg::ST_UPDATE;
            mrc_pkg::ST_UPDATE: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = mrc_pkg::ST_IDLE;
                end
            end
            default: state_next = mrc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= mrc_pkg::ST_IDLE;
        else          state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg    <= s_tuser;
            key_reg   <= {s_tdata[15:0], s_tdata[23:16]};
            dest_reg  <= s_tdata[33:24];
            xfree_reg <= s_tdata[34];
        end
    end

    // ---------------- dividers ----------------
    assign dest_step = mrc_pkg::div_step(dest_rem_reg, dest_quo_reg, cols_eff);
    assign own_step  = mrc_pkg::div_step(own_rem_reg, own_quo_reg, cols_eff);

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            dest_quo_reg <= s_tdata[33:24];
            dest_rem_reg <= '0;
            own_quo_reg  <= own_reg;
            own_rem_reg  <= '0;
            div_cnt_reg  <= mrc_pkg::DIV_CNT_W'(mrc_pkg::DIV_STEPS);
        end else if (state_reg == mrc_pkg::ST_WORK && div_cnt_reg != '0) begin
            dest_quo_reg <= dest_step.quo;
            dest_rem_reg <= dest_step.rem;
            own_quo_reg  <= own_step.quo;
            own_rem_reg  <= own_step.rem;
            div_cnt_reg  <= div_cnt_reg - 1'b1;
        end
    end

    // ---------------- route table ----------------
    mrc_ram #(
        .WIDTH(ENT_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({key_reg, next_calc_reg}),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_vld_reg <= 1'b0;
        end else if (s_accept) begin
            cmp_vld_reg <= 1'b0;
        end else if (state_reg == mrc_pkg::ST_WORK) begin
            cmp_vld_reg <= (cnt_reg < ENTRIES_CNT);
        end
    end

    // walk: issue read at cnt, compare the entry returned in the next cycle
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (state_reg == mrc_pkg::ST_WORK) begin
            if (cnt_reg < ENTRIES_CNT) begin
                cnt_reg     <= cnt_reg + 1'b1;
                cmp_idx_reg <= cnt_reg[IDX_W-1:0];
            end
            if (cmp_vld_reg) begin
                if (valid_reg[cmp_idx_reg] && !found_reg &&
                    ram_rdata[ENT_W-1:RW] == key_reg) begin
                    found_reg     <= 1'b1;
                    match_idx_reg <= cmp_idx_reg;
                    hop_rd_reg    <= ram_rdata[RW-1:0];
                end
                if (!valid_reg[cmp_idx_reg] && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= cmp_idx_reg;
                end
            end
        end
    end

    assign is_head   = (op_reg == mrc_pkg::OP_HEAD);
    assign is_tail   = (op_reg == mrc_pkg::OP_TAIL);
    assign ram_we    = out_load && is_head && (found_reg || free_found_reg);
    assign ram_waddr = found_reg ? match_idx_reg : free_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (out_load) begin
            if (ram_we)                valid_reg[ram_waddr]     <= 1'b1;
            if (is_tail && found_reg)  valid_reg[match_idx_reg] <= 1'b0;
        end
    end

    // ---------------- hop ----------------
    always_comb begin
        xmove = (own_rem_reg != dest_rem_reg);
        ymove = (own_quo_reg != dest_quo_reg);
        case (mode_reg)
            mrc_pkg::MODE_YX:    take_x = !ymove;
            mrc_pkg::MODE_ADAPT: take_x = xmove && (!ymove || xfree_reg);
            default:             take_x = xmove;
        endcase
        // only used when that coordinate differs, so no wrap below zero
        nx = (own_rem_reg < dest_rem_reg) ? own_rem_reg + 1'b1 : own_rem_reg - 1'b1;
        ny = (own_quo_reg > dest_quo_reg) ? {1'b0, own_quo_reg} - 1'b1
                                          : {1'b0, own_quo_reg} + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == mrc_pkg::ST_HOP) begin
            sel_x_reg   <= take_x ? nx : own_rem_reg;
            sel_y_reg   <= take_x ? {1'b0, own_quo_reg} : ny;
            at_dest_reg <= (own_reg == dest_reg);
        end
    end

    assign addr_sum = SW'(sel_y_reg) * SW'(cols_eff) + SW'(sel_x_reg);

    // reduction by MAX_ROUTERS is the low ROUTER_W bits
    always_ff @(posedge aclk) begin
        if (state_reg == mrc_pkg::ST_ADDR) begin
            next_calc_reg <= at_dest_reg ? own_reg : addr_sum[RW-1:0];
        end
    end

    // ---------------- result ----------------
    always_comb begin
        res_next    = '0;
        res_missing = 1'b0;
        res_full    = 1'b0;
        if (is_head) begin
            res_next = next_calc_reg;
            res_full = !found_reg && !free_found_reg;
        end else if (found_reg) begin
            res_next = hop_rd_reg;
        end else begin
            res_missing = 1'b1;
        end
        res_eject = !res_missing && (res_next == own_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_next_reg  <= res_next;
            m_flags_reg <= {res_full, res_missing, res_eject};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_next_reg};
    assign m_tuser  = m_flags_reg;

    // ---------------- checks ----------------
    `MRC_ASSERT_NOW(a_div_done, (state_reg == mrc_pkg::ST_HOP), (div_cnt_reg == '0), "hop computed before division finished")
    `MRC_ASSERT_NOW(a_full_real, (out_load && is_head && !found_reg && !free_found_reg), (&valid_reg), "table full flagged with a free entry")
    `MRC_ASSERT_NEXT(a_tail_frees, (out_load && is_tail && found_reg), (!valid_reg[$past(match_idx_reg)]), "tail did not free its entry")
    `MRC_ASSERT_NOW(a_no_load_busy, (out_load), (!m_valid_reg || m_tready), "result overwrote a held result")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the mesh next-hop unit with its route table.
module testbench;

    localparam int SLOTS = 16;
    localparam logic [1:0] OP_NONE = 2'd3;      // flit kind the block drops
    localparam logic [1:0] MODE_UNUSED = 2'd3;  // falls back to XY
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 200;
    localparam int LIMIT_CYCLES = 600000;

    typedef enum {ACT_FLIT, ACT_WRITE, ACT_SETTLE} act_kind_t;
    typedef enum {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_style_t;

    typedef struct {
        act_kind_t          kind;
        logic [1:0]         op;
        logic [15:0]        msg;
        logic [7:0]         pkt;
        logic [9:0]         dest;
        logic               x_free;
        logic               y_free;
        mrc_pkg::cfg_idx_t  reg_idx;
        logic [9:0]         reg_val;
    } action_t;

    typedef struct packed {
        logic [9:0] next_router;
        logic       eject;
        logic       missing;
        logic       full;
    } route_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [9:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // msg_num, pkt_num, dest_router, x free, y free, zero pad
    logic [1:0]  s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // next_router, zero pad
    logic [2:0]  m_tuser;   // eject_local, route_missing, table_full

    mesh_route_compute_with_route_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // predicted block state
    logic [1:0]  cur_mode;
    logic [5:0]  cur_cols;
    logic [9:0]  cur_own;
    bit          slot_used [SLOTS];
    logic [23:0] slot_key [SLOTS];
    logic [9:0]  slot_hop [SLOTS];

    action_t     pending[$];
    route_t      route_expected[$];
    action_t     offered;
    bit          s_fire, c_fire;
    int          idle_cnt, cycles, n_in, n_out, mismatches;
    int          gap_left, burst_left;

    // stimulus generator state
    logic [23:0] live_keys[$];
    logic [23:0] dead_key;
    int          gen_own, gen_cols;

    function automatic logic [9:0] next_hop_for(input logic [9:0] dest, input logic x_free);
        int unsigned cols, cx, cy, dx, dy, nx, ny, r;
        logic        go_x;
        cols = (cur_cols == 0) ? 1 : cur_cols;
        cx = cur_own % cols;
        cy = cur_own / cols;
        dx = dest % cols;
        dy = dest / cols;
        nx = (cx < dx) ? cx + 1 : cx - 1;
        ny = (cy > dy) ? cy - 1 : cy + 1;
        if (cur_mode == mrc_pkg::MODE_YX)
            go_x = (cy == dy);
        else if (cur_mode == mrc_pkg::MODE_ADAPT)
            go_x = (cx != dx) && (cy == dy || x_free);
        else
            go_x = (cx != dx);
        r = go_x ? cy * cols + nx : ny * cols + cx;
        return r[9:0];
    endfunction

    // Result of one flit; updates the predicted route table.
    function automatic route_t route_flit(input action_t a);
        route_t      res;
        logic [23:0] key;
        int          hit, spare;
        res = '0;
        key = {a.msg, a.pkt};
        hit = -1;
        spare = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_key[i] == key && hit < 0)
                hit = i;
            if (!slot_used[i] && spare < 0)
                spare = i;
        end
        if (a.op == mrc_pkg::OP_HEAD) begin
            // a head already at its destination is ejected here
            res.next_router = (a.dest == cur_own) ? cur_own : next_hop_for(a.dest, a.x_free);
            res.eject = (res.next_router == cur_own);
            if (hit < 0)
                hit = spare;
            if (hit < 0) begin
                res.full = 1'b1;
            end else begin
                slot_used[hit] = 1'b1;
                slot_key[hit] = key;
                slot_hop[hit] = res.next_router;
            end
        end else if (hit < 0) begin
            res.missing = 1'b1;
        end else begin
            res.next_router = slot_hop[hit];
            res.eject = (slot_hop[hit] == cur_own);
            if (a.op == mrc_pkg::OP_TAIL)
                slot_used[hit] = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch on %s at result %0d: got %0d, expected %0d",
                     what, n_out, got, want);
    endtask

    task automatic add_flit(input logic [1:0] op, input logic [15:0] msg, input logic [7:0] pkt,
                            input logic [9:0] dest, input logic xf, input logic yf);
        action_t a;
        a = '{kind: ACT_FLIT, reg_idx: mrc_pkg::CFG_MODE, default: '0};
        a.op = op;
        a.msg = msg;
        a.pkt = pkt;
        a.dest = dest;
        a.x_free = xf;
        a.y_free = yf;
        pending.push_back(a);
    endtask

    // Drain the block, then write all three registers.
    task automatic apply_setting(input logic [1:0] mode, input int cols, input int own);
        action_t a;
        a = '{kind: ACT_SETTLE, reg_idx: mrc_pkg::CFG_MODE, default: '0};
        pending.push_back(a);
        a.kind = ACT_WRITE;
        a.reg_idx = mrc_pkg::CFG_MODE;
        a.reg_val = 10'(mode);
        pending.push_back(a);
        a.reg_idx = mrc_pkg::CFG_COLS;
        a.reg_val = 10'(cols);
        pending.push_back(a);
        a.reg_idx = mrc_pkg::CFG_OWN;
        a.reg_val = 10'(own);
        pending.push_back(a);
        gen_own = own;
        gen_cols = (cols == 0) ? 1 : cols;
    endtask

    // Half near this router, half anywhere, so local ejects and one-step routes show up often.
    function automatic logic [9:0] pick_dest();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 10'(gen_own);
            1: return 10'(gen_own + 1);
            2: return 10'(gen_own - 1);
            3: return 10'(gen_own + gen_cols);
            4: return 10'(gen_own - gen_cols);
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    // Packets as head, data..., tail with random content, plus some noise.
    task automatic gen_traffic(input int count, input int target);
        int          n, pick, idx;
        logic [23:0] k;
        logic [1:0]  o;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                if (live_keys.size() == 0 ||
                    (live_keys.size() < target && $urandom_range(0, 2) == 0)) begin
                    k = 24'($urandom);
                    live_keys.push_back(k);
                    o = mrc_pkg::OP_HEAD;
                end else begin
                    idx = $urandom_range(0, live_keys.size() - 1);
                    k = live_keys[idx];
                    pick = $urandom_range(0, 9);
                    if (pick < 5) begin
                        o = mrc_pkg::OP_DATA;
                    end else if (pick < 8) begin
                        o = mrc_pkg::OP_TAIL;
                        live_keys.delete(idx);
                        dead_key = k;
                    end else begin
                        o = mrc_pkg::OP_HEAD;  // stale entry gets replaced
                    end
                end
            end else begin
                o = 2'($urandom_range(0, 3));
                k = $urandom_range(0, 1) ? dead_key : 24'($urandom);
                if (o == mrc_pkg::OP_HEAD)
                    live_keys.push_back(k);
            end
            add_flit(o, k[23:8], k[7:0], pick_dest(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
            if (o != OP_NONE)
                n++;
        end
    endtask

    // scoreboard: results, config writes, accepted flits
    always @(posedge aclk) begin
        route_t got, want;
        cycles++;
        s_fire = s_tvalid && s_tready;
        c_fire = cfg_valid && cfg_ready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                n_out++;
                got = {m_tdata[9:0], m_tuser[0], m_tuser[1], m_tuser[2]};
                if (route_expected.size() == 0) begin
                    report_mismatch("unexpected item", got.next_router, -1);
                end else begin
                    want = route_expected.pop_front();
                    if (got.next_router != want.next_router)
                        report_mismatch("next_router", got.next_router, want.next_router);
                    if (got.eject != want.eject)
                        report_mismatch("eject_local", got.eject, want.eject);
                    if (got.missing != want.missing)
                        report_mismatch("route_missing", got.missing, want.missing);
                    if (got.full != want.full)
                        report_mismatch("table_full", got.full, want.full);
                end
            end
            if (c_fire) begin
                case (mrc_pkg::cfg_idx_t'(cfg_index))
                    mrc_pkg::CFG_MODE: cur_mode = cfg_data[1:0];
                    mrc_pkg::CFG_COLS: cur_cols = cfg_data[5:0];
                    mrc_pkg::CFG_OWN:  cur_own = cfg_data;
                    default: ;
                endcase
            end
            if (s_fire) begin
                n_in++;
                if (offered.op != OP_NONE)
                    route_expected.push_back(route_flit(offered));
            end
            if (route_expected.size() == 0 && !s_fire)
                idle_cnt = (idle_cnt < SETTLE_CYCLES) ? idle_cnt + 1 : idle_cnt;
            else
                idle_cnt = 0;
        end
    end

    // driver: flits in bursts with random gaps, config writes only while drained
    always @(negedge aclk) begin
        logic v, cv;
        v = 1'b0;
        cv = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_fire)
                pending.delete(0);
            if (cfg_valid && c_fire)
                pending.delete(0);
            if (s_tvalid && !s_fire) begin
                v = 1'b1;
            end else if (cfg_valid && !c_fire) begin
                cv = 1'b1;
            end else if (pending.size() > 0) begin
                case (pending[0].kind)
                    ACT_FLIT: begin
                        if (gap_left > 0) begin
                            gap_left--;
                        end else begin
                            v = 1'b1;
                            offered = pending[0];
                            s_tdata <= {4'b0, offered.y_free, offered.x_free, offered.dest,
                                        offered.pkt, offered.msg};
                            s_tuser <= offered.op;
                            burst_left--;
                            if (burst_left <= 0) begin
                                burst_left = $urandom_range(1, 40);
                                gap_left = ($urandom_range(0, 2) == 0) ? 0 :
                                           $urandom_range(1, $urandom_range(1, 30));
                            end
                        end
                    end
                    ACT_WRITE: begin
                        if (idle_cnt >= SETTLE_CYCLES) begin
                            cv = 1'b1;
                            cfg_index <= pending[0].reg_idx;
                            cfg_data <= pending[0].reg_val;
                        end
                    end
                    default: begin
                        if (idle_cnt >= SETTLE_CYCLES)
                            pending.delete(0);
                    end
                endcase
            end
        end
        s_tvalid <= v;
        cfg_valid <= cv;
    end

    // receiver: changing stall styles, plus long hold-offs that back up the input
    int        hold_left = 0;
    int        style_left = 0;
    int        hold_marks[$] = '{400, 1100};
    rx_style_t style = RX_OPEN;

    always @(negedge aclk) begin
        logic r;
        if (hold_left > 0) begin
            hold_left--;
            r = 1'b0;
        end else if (hold_marks.size() > 0 && n_in >= hold_marks[0]) begin
            hold_marks.delete(0);
            hold_left = HOLD_CYCLES;
            r = 1'b0;
        end else begin
            if (style_left == 0) begin
                style = rx_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(20, 300);
            end
            style_left--;
            case (style)
                RX_OPEN:   r = 1'b1;
                RX_COIN:   r = 1'($urandom_range(0, 1));
                RX_MOSTLY: r = ($urandom_range(0, 7) != 0);
                default:   r = ($urandom_range(0, 3) == 0);
            endcase
        end
        m_tready <= r;
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_tready = 1'b0;
        s_fire = 1'b0;
        c_fire = 1'b0;
        idle_cnt = 0;
        cycles = 0;
        n_in = 0;
        n_out = 0;
        mismatches = 0;
        gap_left = 0;
        burst_left = 1;
        offered = '{kind: ACT_FLIT, reg_idx: mrc_pkg::CFG_MODE, default: '0};
        cur_mode = mrc_pkg::MODE_XY;
        cur_cols = 6'd4;
        cur_own = '0;
        for (int i = 0; i < SLOTS; i++)
            slot_used[i] = 1'b0;
        dead_key = '0;

        // directed: 4 columns, router 5 sits at column 1, row 1
        apply_setting(mrc_pkg::MODE_XY, 4, 5);
        add_flit(mrc_pkg::OP_HEAD, 16'h0000, 8'h00, 10'd5, 1'b0, 1'b0);  // already at destination
        add_flit(mrc_pkg::OP_DATA, 16'h0000, 8'h00, 10'd0, 1'b0, 1'b0);
        add_flit(mrc_pkg::OP_TAIL, 16'h0000, 8'h00, 10'd0, 1'b0, 1'b0);
        add_flit(mrc_pkg::OP_DATA, 16'h0000, 8'h00, 10'd0, 1'b0, 1'b0);  // entry gone
        add_flit(OP_NONE, 16'h0000, 8'h00, 10'd1023, 1'b1, 1'b1);
        for (int i = 1; i <= 14; i++)
            add_flit(mrc_pkg::OP_HEAD, 16'h0100 + 16'(i), 8'(i), 10'($urandom_range(0, 1023)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        add_flit(mrc_pkg::OP_HEAD, 16'hFFFF, 8'hFF, 10'd1023, 1'b1, 1'b1);
        add_flit(mrc_pkg::OP_HEAD, 16'h0200, 8'h10, 10'd0, 1'b0, 1'b0);   // last free entry
        add_flit(mrc_pkg::OP_HEAD, 16'h0200, 8'h11, 10'd15, 1'b1, 1'b0);  // no room left
        add_flit(mrc_pkg::OP_HEAD, 16'h0101, 8'h01, 10'd15, 1'b0, 1'b1);  // replace while full
        add_flit(mrc_pkg::OP_DATA, 16'h0200, 8'h11, 10'd0, 1'b0, 1'b0);
        add_flit(mrc_pkg::OP_TAIL, 16'hFFFF, 8'hFF, 10'd0, 1'b0, 1'b0);
        add_flit(mrc_pkg::OP_DATA, 16'h0101, 8'h01, 10'd0, 1'b0, 1'b0);
        for (int i = 1; i <= 14; i++)
            live_keys.push_back({16'h0100 + 16'(i), 8'(i)});
        live_keys.push_back({16'h0200, 8'h10});

        apply_setting(mrc_pkg::MODE_YX, 1, 0);
        gen_traffic(170, 6);
        apply_setting(mrc_pkg::MODE_ADAPT, 32, 1023);
        gen_traffic(170, 12);
        apply_setting(mrc_pkg::MODE_XY, 32, 0);
        gen_traffic(170, 18);
        apply_setting(mrc_pkg::MODE_ADAPT, 7, 500);
        gen_traffic(170, 10);
        apply_setting(mrc_pkg::MODE_YX, 13, 1023);
        gen_traffic(170, 18);
        apply_setting(mrc_pkg::MODE_ADAPT, 1, 1023);
        gen_traffic(170, 8);
        apply_setting(MODE_UNUSED, 5, 37);
        gen_traffic(170, 12);
        apply_setting(mrc_pkg::MODE_ADAPT, 0, 9);        // zero columns act as one
        gen_traffic(170, 6);
        apply_setting(mrc_pkg::MODE_XY, 40, 700);
        gen_traffic(170, 14);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (!(pending.size() == 0 && route_expected.size() == 0 &&
                 idle_cnt >= SETTLE_CYCLES) && cycles < LIMIT_CYCLES)
            @(posedge aclk);
        if (cycles >= LIMIT_CYCLES)
            $display("mesh_route_compute_with_route_table test failed");
        else if (mismatches == 0)
            $display("mesh_route_compute_with_route_table test passed");
        else
            $display("mesh_route_compute_with_route_table test failed");
        $finish;
    end

endmodule
